### sv/mvdp_pkg.sv
// Shared types and constants for the median-of-valid-diameter-pairs block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package mvdp_pkg;

	localparam int RAD_W         = 24;   // radius, unsigned Q16.8
	localparam int DIAM_W        = 25;   // diameter, unsigned Q17.8
	localparam int DIV_W         = 16;   // scale divisor
	localparam int MAX_PAIRS_DEF = 128;  // default depth of the sort chain
	localparam int MIN_SORTED    = 3;    // below this count use the first diameter

	typedef logic [RAD_W-1:0]  radius_t;
	typedef logic [DIAM_W-1:0] diam_t;
	typedef logic [DIV_W-1:0]  divisor_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic ins;  // insert the broadcast diameter in sorted order
		logic shl;  // move every entry one cell toward cell 0
	} cell_ctl_t;

endpackage
`default_nettype wire

### sv/mvdp_cell.sv
// One cell of the sorted insertion chain: holds one diameter.
// Depends on mvdp_pkg.
`default_nettype none
module mvdp_cell #(
	parameter int CW  = 8,
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire mvdp_pkg::cell_ctl_t ctl,
	input  wire logic [CW-1:0]     count,
	input  wire mvdp_pkg::diam_t   d,
	input  wire mvdp_pkg::diam_t   left_val,
	input  wire logic              left_gt,
	input  wire mvdp_pkg::diam_t   right_val,
	output mvdp_pkg::diam_t        val,
	output logic                   gt
);
	import mvdp_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	diam_t val_q;

	// unoccupied cells behave as larger than any diameter
	assign gt  = (IDX_C >= count) || (val_q > d);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt) begin
				val_q <= left_gt ? left_val : d;
			end
		end else if (ctl.shl) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire

### sv/mvdp_div.sv
// Restoring divider, one quotient bit per cycle: diameter / scale divisor.
// Depends on mvdp_pkg.
`default_nettype none
module mvdp_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire mvdp_pkg::diam_t   dividend,
	input  wire mvdp_pkg::divisor_t divisor,
	output logic                   done,
	output mvdp_pkg::diam_t        quotient
);
	import mvdp_pkg::*;

	localparam int CNT_W = $clog2(DIAM_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIAM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	divisor_t         rem_q;
	divisor_t         dsr_q;
	diam_t            dvd_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   diff;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIAM_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// keep the difference when it did not go negative
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
			end
			dvd_q <= {dvd_q[DIAM_W-2:0], ~diff[DIV_W]};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

### sv/median_of_valid_diameter_pairs.sv
// A word without last_pair leaves in_ready high, so intake goes on.
// A word with last_pair ends the frame: the chain drains floor(n/2) cells toward cell 0
// for n >= 3 stored diameters, none otherwise, then the 25-step serial divider runs.
// Throughput: one word per cycle inside a frame; in_ready is low from frame end until
// the result is loaded, longer while the previous result word is still waiting.
// Reset (arst_n low, asynchronous): empty frame, no pending result, divisor 1.
`default_nettype none
module median_of_valid_diameter_pairs #(
	parameter int MAX_PAIRS = mvdp_pkg::MAX_PAIRS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input words: one pair of opposite radii each
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mvdp_pkg::radius_t  radius_first,
	input  wire mvdp_pkg::radius_t  radius_second,
	input  wire logic               first_present,
	input  wire logic               second_present,
	input  wire logic               last_pair,
	// result words: one per frame
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mvdp_pkg::diam_t         median_diameter,
	output logic                    no_result,
	// scale divisor register
	input  wire logic               cfg_we,
	input  wire mvdp_pkg::divisor_t cfg_data
);
	import mvdp_pkg::*;

	// count width holds MAX_PAIRS itself
	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_PAIRS);
	localparam logic [CW-1:0] MIN_C = CW'(MIN_SORTED);

	typedef enum logic [1:0] {
		S_IDLE,   // take words, insert valid diameters
		S_SHIFT,  // drain the chain toward cell 0 until the median sits there
		S_DIV,    // serial divide of the chosen diameter
		S_HOLD    // wait for the result register to free up
	} state_t;

	state_t    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] shift_q;
	diam_t     first_q;
	divisor_t  div_q;
	logic      out_valid_q;
	diam_t     out_median_q;
	logic      out_empty_q;

	logic      accept;
	logic      ins_now;
	logic [CW-1:0] cnt_new;
	diam_t     d_new;
	cell_ctl_t ctl;
	logic      div_start;
	diam_t     dividend;
	divisor_t  divisor;
	logic      div_done;
	diam_t     quotient;
	logic      load_out;

	diam_t cell_val [MAX_PAIRS];
	logic  cell_gt  [MAX_PAIRS];

	always_comb begin
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		// a pair counts only with both points present and room left in the chain
		ins_now  = accept && first_present && second_present && (count_q < MAX_C);
		cnt_new  = count_q + CW'(ins_now);
		d_new    = DIAM_W'(radius_first) + DIAM_W'(radius_second);

		ctl.ins   = ins_now;
		ctl.shl   = (state_q == S_SHIFT) && (shift_q != '0);
		div_start = (state_q == S_SHIFT) && (shift_q == '0);

		// empty frame divides zero, which flags itself empty
		if (count_q == '0) begin
			dividend = '0;
		end else if (count_q < MIN_C) begin
			dividend = first_q;
		end else begin
			dividend = cell_val[0];
		end
		divisor  = (div_q == '0) ? divisor_t'(1) : div_q;
		load_out = (state_q == S_HOLD) && (!out_valid_q || out_ready);
	end

	// sort chain: ascending from cell 0; insertion pushes larger entries right,
	// the drain at frame end pulls everything left
	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		diam_t lv;
		logic  lg;
		diam_t rv;
		if (i == 0) begin : g_head
			assign lv = d_new;
			assign lg = 1'b0;
		end else begin : g_body
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == MAX_PAIRS - 1) begin : g_tail
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end
		mvdp_cell #(
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.d        (d_new),
			.left_val (lv),
			.left_gt  (lg),
			.right_val(rv),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	mvdp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (divisor),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			shift_q      <= '0;
			first_q      <= '0;
			div_q        <= divisor_t'(1);
			out_valid_q  <= 1'b0;
			out_median_q <= '0;
			out_empty_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				div_q <= cfg_data;
			end
			// raise the result word on a load, drop it once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ins_now) begin
						count_q <= cnt_new;
						if (count_q == '0) begin
							first_q <= d_new;
						end
					end
					if (accept && last_pair) begin
						// median index is n/2: advance the chain that many cells
						shift_q <= (cnt_new >= MIN_C) ? (cnt_new >> 1) : '0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_q != '0) begin
						shift_q <= shift_q - 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (load_out) begin
						out_median_q <= quotient;
						out_empty_q  <= (quotient == '0);
						count_q      <= '0;
						first_q      <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign median_diameter = out_median_q;
	assign no_result       = out_empty_q;

endmodule
`default_nettype wire

### sv/mvdp_chk.sv
// Port-level checks for median_of_valid_diameter_pairs, bound to the top level.
// Depends on mvdp_pkg.
`default_nettype none
module mvdp_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              last_pair,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire mvdp_pkg::diam_t   median_diameter,
	input wire logic              no_result
);
	import mvdp_pkg::*;

	// an empty result carries a zero diameter
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_result |-> median_diameter == '0)
		else $error("empty result with nonzero diameter");

	// a non-empty result carries a nonzero diameter
	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_result |-> median_diameter != '0)
		else $error("non-empty result with zero diameter");

	// the frame end stops intake while the median is worked out
	a_frame_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_pair |=> !in_ready)
		else $error("input taken right after frame end");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(median_diameter) && $stable(no_result))
		else $error("result word changed while stalled");

endmodule

bind median_of_valid_diameter_pairs mvdp_chk u_mvdp_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last_pair      (last_pair),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.median_diameter(median_diameter),
	.no_result      (no_result)
);
`default_nettype wire

### bench/mvdp_median_check.sv
// Result checker for median_of_valid_diameter_pairs: watches the pair, result and divisor
// ports, keeps its own sorted frame of diameters and compares every result word.
// Depends on mvdp_pkg for the field types and the sort constants.
module mvdp_median_check
	import mvdp_pkg::*;
#(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  radius_t  radius_first,
	input  radius_t  radius_second,
	input  logic     first_present,
	input  logic     second_present,
	input  logic     last_pair,
	input  logic     out_valid,
	input  logic     out_ready,
	input  diam_t    median_diameter,
	input  logic     no_result,
	input  logic     cfg_we,
	input  divisor_t cfg_data,
	output int       results_owed,
	output int       mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		diam_t median;
		logic  empty;
	} median_word_t;

	diam_t        ladder [MAX_PAIRS];
	diam_t        first_diam;
	int           stored;
	divisor_t     divisor;
	median_word_t median_q [$];

	// Fold one accepted pair into the frame; on the closing pair queue the median word.
	task automatic fold_pair(input radius_t ra, input radius_t rb, input logic both,
			input logic last);
		diam_t        d;
		diam_t        chosen;
		diam_t        q;
		int           pos;
		median_word_t w;
		if (both && stored < MAX_PAIRS) begin
			d = diam_t'(ra) + diam_t'(rb);
			if (stored == 0)
				first_diam = d;
			pos = stored;
			while (pos > 0 && ladder[pos-1] > d) begin
				ladder[pos] = ladder[pos-1];
				pos--;
			end
			ladder[pos] = d;
			stored++;
		end
		if (last) begin
			q = '0;
			if (stored != 0) begin
				chosen = (stored < MIN_SORTED) ? first_diam : ladder[stored/2];
				q = chosen / diam_t'((divisor == '0) ? divisor_t'(1) : divisor);
			end
			w.empty  = (q == '0);
			w.median = q;
			median_q.push_back(w);
			stored     = 0;
			first_diam = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		median_word_t want;
		if (!arst_n) begin
			stored       = 0;
			first_diam   = '0;
			divisor      = divisor_t'(1);
			median_q.delete();
			results_owed = 0;
			mismatches   = 0;
		end else begin
			if (cfg_we)
				divisor = cfg_data;
			if (in_valid && in_ready)
				fold_pair(radius_first, radius_second, first_present && second_present,
					last_pair);
			if (out_valid && out_ready) begin
				if (median_q.size() == 0) begin
					$display("%0t ns: unexpected result word, expected none, got %0d / %0b",
						$time, median_diameter, no_result);
					mismatches++;
				end else begin
					want = median_q.pop_front();
					if (median_diameter !== want.median) begin
						$display("%0t ns: median_diameter expected %0d, got %0d",
							$time, want.median, median_diameter);
						mismatches++;
					end
					if (no_result !== want.empty) begin
						$display("%0t ns: no_result expected %0b, got %0b",
							$time, want.empty, no_result);
						mismatches++;
					end
				end
			end
			results_owed = median_q.size();
		end
	end

endmodule

### bench/median_of_valid_diameter_pairs_tb.sv
// Top of the median_of_valid_diameter_pairs testbench: clock, reset, pair and divisor
// stimulus, result-side back-pressure and the verdict.
// Depends on mvdp_pkg, the block itself and mvdp_median_check.
module median_of_valid_diameter_pairs_tb;
	import mvdp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int RX_HOLD_CYCLES = 400;
	// longest frame-end latency (half a full chain plus the divider) with margin
	localparam int DRAIN_CYCLES   = MAX_PAIRS_DEF / 2 + 40;
	localparam int PHASE_WORDS    = 190;
	localparam int PHASES         = 8;

	logic     clk;
	logic     arst_n         = 1'b0;
	logic     in_valid       = 1'b0;
	logic     in_ready;
	radius_t  radius_first   = '0;
	radius_t  radius_second  = '0;
	logic     first_present  = 1'b0;
	logic     second_present = 1'b0;
	logic     last_pair      = 1'b0;
	logic     out_valid;
	logic     out_ready      = 1'b0;
	diam_t    median_diameter;
	logic     no_result;
	logic     cfg_we         = 1'b0;
	divisor_t cfg_data       = '0;

	int       results_owed;
	int       mismatches;
	int       cycle_count    = 0;
	int       tx_calm        = 0;     // words left in a stretch with no sender gaps
	radius_t  last_radius    = '0;    // reused now and then to make equal diameters
	bit       rx_hold        = 1'b0;  // request for one long receiver hold-off

	median_of_valid_diameter_pairs uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.radius_first   (radius_first),
		.radius_second  (radius_second),
		.first_present  (first_present),
		.second_present (second_present),
		.last_pair      (last_pair),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_diameter(median_diameter),
		.no_result      (no_result),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data)
	);

	mvdp_median_check median_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.radius_first   (radius_first),
		.radius_second  (radius_second),
		.first_present  (first_present),
		.second_present (second_present),
		.last_pair      (last_pair),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_diameter(median_diameter),
		.no_result      (no_result),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.results_owed   (results_owed),
		.mismatches     (mismatches)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run; a hung handshake ends up here.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Idle cycles before the next input word: mostly none or a few, rarely a long gap,
	// and now and then a calm stretch with no gaps at all.
	function automatic int word_gap();
		int r;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		if (r < 98)
			return $urandom_range(15, 40);
		tx_calm = $urandom_range(30, 120);
		return 0;
	endfunction

	// Mix of edge radii, small ones, repeats and full-range values.
	function automatic radius_t pick_radius();
		radius_t v;
		case ($urandom_range(0, 9))
		0: v = '0;
		1: v = '1;
		2: v = radius_t'($urandom_range(0, 255));
		3: v = last_radius;
		default: v = radius_t'($urandom);
		endcase
		last_radius = v;
		return v;
	endfunction

	// Offer one word at a falling edge and hold it until the rising edge that takes it.
	task automatic send_word(input radius_t ra, input radius_t rb, input logic pa,
			input logic pb, input logic last);
		int gap;
		gap = word_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		radius_first   <= ra;
		radius_second  <= rb;
		first_present  <= pa;
		second_present <= pb;
		last_pair      <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// One frame of len words; valid_pct of them carry both radii, the rest random flags.
	task automatic send_frame(input int len, input int valid_pct);
		logic pa;
		logic pb;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < valid_pct) begin
				pa = 1'b1;
				pb = 1'b1;
			end else begin
				pa = 1'($urandom_range(0, 1));
				pb = 1'($urandom_range(0, 1));
			end
			send_word(pick_radius(), pick_radius(), pa, pb, i == len - 1);
		end
	endtask

	// Random frames until about budget words went out; mostly short frames.
	task automatic run_frames(input int budget);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 6);
			else if (r < 92)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(25, 70);
			send_frame(len, 75);
			sent += len;
		end
	endtask

	// Drop valid, wait for every owed result, then let the chain and divider drain.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (results_owed == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_divisor(input divisor_t v);
		settle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Result side: random stalls, calm stretches, and one long hold-off on request
	// so the block fills up and pushes back on its input.
	initial begin : receiver
		int gap;
		int calm;
		int r;
		gap  = 0;
		calm = 0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
				rx_hold = 1'b0;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				if (calm > 0) begin
					calm--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 12)
						gap = $urandom_range(1, 3);
					else if (r < 15)
						gap = $urandom_range(5, 12);
					else if (r < 17)
						gap = $urandom_range(20, 60);
					else if (r == 99)
						calm = $urandom_range(50, 200);
				end
			end
		end
	end

	initial begin : stimulus
		divisor_t div;
		int       budget;

		// Hold reset, then release it at a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset divisor of one.
		// Frame with only a closing word that has no radii: empty result.
		send_word('0, '0, 1'b0, 1'b0, 1'b1);
		// Single pair of largest radii: full-scale diameter.
		send_word('1, '1, 1'b1, 1'b1, 1'b1);
		// Single pair of zero radii: zero diameter gives an empty result.
		send_word('0, '0, 1'b1, 1'b1, 1'b1);
		// One radius missing on each word: nothing stored.
		send_word(24'd5, 24'd6, 1'b1, 1'b0, 1'b0);
		send_word(24'd7, 24'd8, 1'b0, 1'b1, 1'b0);
		send_word('1, '0, 1'b1, 1'b0, 1'b1);
		// Two pairs: the first one wins even though it is larger.
		send_word(24'd1000, 24'd1000, 1'b1, 1'b1, 1'b0);
		send_word(24'd10, 24'd10, 1'b1, 1'b1, 1'b1);
		// Three pairs out of order around a skipped word: middle of the sort.
		send_word(24'd300, '0, 1'b1, 1'b1, 1'b0);
		send_word(24'd100, '0, 1'b1, 1'b1, 1'b0);
		send_word(24'd999, 24'd999, 1'b0, 1'b0, 1'b0);
		send_word(24'd200, '0, 1'b1, 1'b1, 1'b1);
		// Four pairs with duplicates, closing word without a pair.
		send_word(24'd50, 24'd50, 1'b1, 1'b1, 1'b0);
		send_word(24'h800000, 24'h800000, 1'b1, 1'b1, 1'b0);
		send_word(24'd50, 24'd50, 1'b1, 1'b1, 1'b0);
		send_word(24'd1, 24'd2, 1'b1, 1'b1, 1'b0);
		send_word(24'hABCDEF, 24'h123456, 1'b1, 1'b0, 1'b1);
		// Five pairs with equal large diameters from crossed radii.
		send_word('1, 24'd1, 1'b1, 1'b1, 1'b0);
		send_word(24'd1, '1, 1'b1, 1'b1, 1'b0);
		send_word(24'd7, '0, 1'b1, 1'b1, 1'b0);
		send_word('0, 24'd7, 1'b1, 1'b1, 1'b0);
		send_word(24'd3, 24'd3, 1'b1, 1'b1, 1'b1);

		// Random phases, each under its own divisor, with the sender paused in between.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: div = divisor_t'(1);
			1: div = '0;                         // zero acts as one
			2: div = '1;                         // largest divisor: diameters below it come out empty
			3: div = divisor_t'(2);
			4: div = divisor_t'($urandom_range(3, 65534));
			5: div = divisor_t'(256);
			6: div = divisor_t'(5);
			default: div = divisor_t'(3);
			endcase
			set_divisor(div);
			budget = PHASE_WORDS;
			// Overfill the store: pairs past the chain depth are dropped.
			if (phase == 3) begin
				send_frame(140, 100);
				budget -= 140;
			end
			if (phase == 6) begin
				send_frame(150, 93);
				budget -= 150;
			end
			// Stall the result side for a long stretch while frames keep coming.
			if (phase == 4)
				rx_hold = 1'b1;
			run_frames(budget);
		end

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
